// ----- hw/rtl/tlc_pkg.sv -----
// Shared constants for the two-level LRU cache cost model.
package tlc_pkg;
	localparam int WAYS_DEF      = 8;
	localparam int L1_SETS_DEF   = 8;
	localparam int L2_SETS_DEF   = 64;
	localparam int ADDR_BITS_DEF = 32;

	localparam int ADDR_IN_W = 32;
	localparam int COST_W    = 16;
	localparam int TOTAL_W   = 48;
	localparam int CFG_AW    = 5;
	localparam int CFG_DW    = 32;

	localparam logic [2:0] CFG_L1_OFF   = 3'd0;
	localparam logic [2:0] CFG_L1_SETB  = 3'd1;
	localparam logic [2:0] CFG_L2_OFF   = 3'd2;
	localparam logic [2:0] CFG_L2_SETB  = 3'd3;
	localparam logic [2:0] CFG_WAYS     = 3'd4;
	localparam logic [2:0] CFG_L1_COST  = 3'd5;
	localparam logic [2:0] CFG_L2_COST  = 3'd6;
	localparam logic [2:0] CFG_MEM_COST = 3'd7;
endpackage

// ----- hw/rtl/tlc_in_if.sv -----
// Address channel carrying one access per transaction.
interface tlc_in_if;
	import tlc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ADDR_IN_W-1:0] address;
	modport source (output valid, output address, input ready);
	modport sink (input valid, input address, output ready);
endinterface

// ----- hw/rtl/tlc_out_if.sv -----
// Result channel carrying hit flags and costs per transaction.
interface tlc_out_if;
	import tlc_pkg::*;
	logic               valid;
	logic               ready;
	logic               l1_hit;
	logic               l2_hit;
	logic [COST_W-1:0]  access_cost;
	logic [TOTAL_W-1:0] total_cost;
	modport source (output valid, output l1_hit, output l2_hit, output access_cost,
		output total_cost, input ready);
	modport sink (input valid, input l1_hit, input l2_hit, input access_cost,
		input total_cost, output ready);
endinterface

// ----- hw/rtl/two_level_lru_cache_cost_model_top.sv -----
// Two-level LRU cache cost model: top level with APB registers and tag RAMs.
// An accepted access reads its L1 set row; an L1 hit finishes in ST_CMP1, a miss
// reads L2 and finishes in ST_CMP2, and no new access is taken until it finishes;
// each level is one read-modify-write of a whole set row in its tag RAM.
// Reset: registers take their defaults, total clears, then a clearing pass over
// max(L1_SETS, L2_SETS) set rows zeroes the fill counts before the first accept.
module two_level_lru_cache_cost_model_top #(
	parameter int WAYS      = tlc_pkg::WAYS_DEF,
	parameter int L1_SETS   = tlc_pkg::L1_SETS_DEF,
	parameter int L2_SETS   = tlc_pkg::L2_SETS_DEF,
	parameter int ADDR_BITS = tlc_pkg::ADDR_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tlc_pkg::CFG_AW-1:0]  paddr,
	input  logic [tlc_pkg::CFG_DW-1:0]  pwdata,
	output logic [tlc_pkg::CFG_DW-1:0]  prdata,
	output logic                        pready,
	tlc_in_if.sink                      in_ch,
	tlc_out_if.source                   out_ch
);
	import tlc_pkg::*;

	localparam int FW    = $clog2(WAYS + 1);
	localparam int TW    = ADDR_BITS;
	localparam int ROW_W = FW + WAYS * TW;
	localparam int S1W   = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
	localparam int S2W   = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
	localparam int MAXS  = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
	localparam int CLRW  = (MAXS > 1) ? $clog2(MAXS) : 1;

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_CMP1 = 2'd2;
	localparam logic [1:0] ST_CMP2 = 2'd3;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	logic [4:0]        off1_q, off2_q;
	logic [1:0]        sb1_q;
	logic [2:0]        sb2_q;
	logic [3:0]        ways_q;
	logic [COST_W-1:0] c1_q, c2_q, cm_q;

	logic [1:0]        state_q;
	logic [CLRW-1:0]   clr_q;
	logic [TW-1:0]     addr_q;
	logic [S1W-1:0]    set1_q;
	logic [S2W-1:0]    set2_q;
	logic [TOTAL_W-1:0] total_q;

	logic               out_valid_q;
	logic               out_l1_q, out_l2_q;
	logic [COST_W-1:0]  out_cost_q;
	logic [TOTAL_W-1:0] out_total_q;

	logic             l1_we, l1_re, l2_we, l2_re;
	logic [S1W-1:0]   l1_waddr, l1_raddr;
	logic [S2W-1:0]   l2_waddr, l2_raddr;
	logic [ROW_W-1:0] l1_wdata, l2_wdata, l1_rdata, l2_rdata;

	logic [TW-1:0]    addr_m, blk1_in, blk1_q, blk2_q;
	logic [FW-1:0]    nw;
	logic [ROW_W:0]   upd1, upd2;
	logic             in_acc, fin_ok, clr_done, cfg_wr, fin_go;
	logic [COST_W-1:0] cost;
	logic [TOTAL_W:0]  sum;

	function automatic logic [S1W-1:0] set1_of(input logic [TW-1:0] blk,
		input logic [1:0] bits);
		logic [7:0]     v;
		logic [S1W-1:0] r;
		v = blk[7:0] & ((8'd1 << bits) - 8'd1);
		r = '0;
		for (int k = 0; k < 8; k++) begin
			if (v == 8'(k)) r = S1W'(k % L1_SETS);
		end
		return r;
	endfunction

	function automatic logic [S2W-1:0] set2_of(input logic [TW-1:0] blk,
		input logic [2:0] bits);
		logic [7:0]     v;
		logic [S2W-1:0] r;
		v = blk[7:0] & ((8'd1 << bits) - 8'd1);
		r = '0;
		for (int k = 0; k < 128; k++) begin
			if (v == 8'(k)) r = S2W'(k % L2_SETS);
		end
		return r;
	endfunction

	function automatic logic [ROW_W:0] lru_upd(input logic [ROW_W-1:0] row,
		input logic [TW-1:0] blk, input logic [FW-1:0] nwy);
		logic [TW-1:0]    t [WAYS];
		logic [TW-1:0]    o [WAYS];
		logic [FW-1:0]    n, p, last, fill;
		logic             hit;
		logic [ROW_W-1:0] r;
		n = row[ROW_W-1 -: FW];
		if (n > FW'(WAYS)) n = FW'(WAYS);
		for (int j = 0; j < WAYS; j++) t[j] = row[j*TW +: TW];
		hit = 1'b0;
		p = '0;
		for (int j = WAYS - 1; j >= 0; j--) begin
			if (FW'(j) < n && t[j] == blk) begin
				hit = 1'b1;
				p = FW'(j);
			end
		end
		if (hit) begin
			last = n - FW'(1);
			fill = n;
		end else if (n < nwy) begin
			p = n;
			last = n;
			fill = n + FW'(1);
		end else begin
			p = '0;
			last = n - FW'(1);
			fill = n;
		end
		for (int j = 0; j < WAYS; j++) begin
			if (FW'(j) == last) o[j] = blk;
			else if (j < WAYS - 1 && FW'(j) >= p && FW'(j) < last) o[j] = t[(j+1) % WAYS];
			else o[j] = t[j];
		end
		r[ROW_W-1 -: FW] = fill;
		for (int j = 0; j < WAYS; j++) r[j*TW +: TW] = o[j];
		return {hit, r};
	endfunction

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[4:2])
			CFG_L1_OFF:   prdata = CFG_DW'(off1_q);
			CFG_L1_SETB:  prdata = CFG_DW'(sb1_q);
			CFG_L2_OFF:   prdata = CFG_DW'(off2_q);
			CFG_L2_SETB:  prdata = CFG_DW'(sb2_q);
			CFG_WAYS:     prdata = CFG_DW'(ways_q);
			CFG_L1_COST:  prdata = CFG_DW'(c1_q);
			CFG_L2_COST:  prdata = CFG_DW'(c2_q);
			CFG_MEM_COST: prdata = CFG_DW'(cm_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off1_q <= 5'd4;
			sb1_q  <= 2'd0;
			off2_q <= 5'd7;
			sb2_q  <= 3'd2;
			ways_q <= 4'd8;
			c1_q   <= 16'd3;
			c2_q   <= 16'd55;
			cm_q   <= 16'd3639;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				CFG_L1_OFF:   off1_q <= pwdata[4:0];
				CFG_L1_SETB:  sb1_q  <= pwdata[1:0];
				CFG_L2_OFF:   off2_q <= pwdata[4:0];
				CFG_L2_SETB:  sb2_q  <= pwdata[2:0];
				CFG_WAYS:     ways_q <= pwdata[3:0];
				CFG_L1_COST:  c1_q   <= pwdata[15:0];
				CFG_L2_COST:  c2_q   <= pwdata[15:0];
				CFG_MEM_COST: cm_q   <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		if (ways_q == 4'd0) nw = FW'(1);
		else if (32'(ways_q) > WAYS) nw = FW'(WAYS);
		else nw = FW'(ways_q);
	end

	assign addr_m  = TW'(in_ch.address);
	assign blk1_in = addr_m >> off1_q;
	assign blk1_q  = addr_q >> off1_q;
	assign blk2_q  = addr_q >> off2_q;
	assign upd1    = lru_upd(l1_rdata, blk1_q, nw);
	assign upd2    = lru_upd(l2_rdata, blk2_q, nw);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign fin_ok      = !out_valid_q || out_ch.ready;
	assign clr_done    = (clr_q == CLRW'(MAXS - 1));
	assign fin_go      = (state_q == ST_CMP1 && upd1[ROW_W] && fin_ok) ||
		(state_q == ST_CMP2 && fin_ok);

	always_comb begin
		l1_we    = 1'b0;
		l2_we    = 1'b0;
		l1_re    = 1'b0;
		l2_re    = 1'b0;
		l1_waddr = set1_q;
		l2_waddr = set2_q;
		l1_wdata = upd1[ROW_W-1:0];
		l2_wdata = upd2[ROW_W-1:0];
		l1_raddr = set1_of(blk1_in, sb1_q);
		l2_raddr = set2_of(blk2_q, sb2_q);
		unique case (state_q)
			ST_CLR: begin
				l1_we    = ({1'b0, clr_q} < (CLRW+1)'(L1_SETS));
				l2_we    = ({1'b0, clr_q} < (CLRW+1)'(L2_SETS));
				l1_waddr = clr_q[S1W-1:0];
				l2_waddr = clr_q[S2W-1:0];
				l1_wdata = '0;
				l2_wdata = '0;
			end
			ST_IDLE: l1_re = in_acc;
			ST_CMP1: begin
				l1_we = !upd1[ROW_W] || fin_ok;
				l2_re = !upd1[ROW_W];
			end
			ST_CMP2: l2_we = fin_ok;
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == ST_CMP1) cost = c1_q;
		else if (upd2[ROW_W]) cost = c2_q;
		else cost = cm_q;
	end
	assign sum = {1'b0, total_q} + (TOTAL_W+1)'(cost);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CLRW'(1);
					if (clr_done) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_acc) state_q <= ST_CMP1;
				ST_CMP1: begin
					if (!upd1[ROW_W]) state_q <= ST_CMP2;
					else if (fin_ok) state_q <= ST_IDLE;
				end
				ST_CMP2: if (fin_ok) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (fin_go) begin
				out_valid_q <= 1'b1;
				total_q     <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= addr_m;
			set1_q <= set1_of(blk1_in, sb1_q);
		end
		if (state_q == ST_CMP1) begin
			set2_q <= l2_raddr;
		end
		if (fin_go) begin
			out_l1_q    <= (state_q == ST_CMP1);
			out_l2_q    <= (state_q == ST_CMP2) && upd2[ROW_W];
			out_cost_q  <= cost;
			out_total_q <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.l1_hit      = out_l1_q;
	assign out_ch.l2_hit      = out_l2_q;
	assign out_ch.access_cost = out_cost_q;
	assign out_ch.total_cost  = out_total_q;

	tlc_ram #(.W(ROW_W), .D(L1_SETS)) u_l1_ram (
		.clk   (clk),
		.we    (l1_we),
		.waddr (l1_waddr),
		.wdata (l1_wdata),
		.re    (l1_re),
		.raddr (l1_raddr),
		.rdata (l1_rdata)
	);

	tlc_ram #(.W(ROW_W), .D(L2_SETS)) u_l2_ram (
		.clk   (clk),
		.we    (l2_we),
		.waddr (l2_waddr),
		.wdata (l2_wdata),
		.re    (l2_re),
		.raddr (l2_raddr),
		.rdata (l2_rdata)
	);

	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.l1_hit |-> !out_ch.l2_hit)
		else $error("both hit flags set");

	a_acc_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> state_q == ST_CMP1)
		else $error("accepted access not in lookup");

	a_l1_miss: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP1 && !upd1[ROW_W] |=> state_q == ST_CMP2)
		else $error("L1 miss skipped L2 lookup");

	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CLR |-> total_q >= $past(total_q))
		else $error("total decreased");
endmodule

// ----- hw/rtl/tlc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tlc_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                 wdata,
	input  logic                         re,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                 rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
